// ===== rtl/lru_page_replacement_defines.svh =====
// assertion helpers for the lru page replacement block
// expect clk and arst_n in the scope of use
`ifndef LRU_PAGE_REPLACEMENT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_DEFINES_SVH

// same-cycle implication
`define LRU_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lru assertion failed");

// next-cycle implication
`define LRU_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lru assertion failed");

`endif

// ===== rtl/lru_pkg.sv =====
`default_nettype none

package lru_pkg;

	localparam int FRAMES    = 8;
	localparam int PAGE_BITS = 16;
	localparam int SLOT_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int FILL_W    = $clog2(FRAMES + 1);
	localparam int CFG_W     = 4;
	localparam int CNT_W     = 20;

	localparam logic [CFG_W-1:0] FRAME_COUNT_RESET = CFG_W'(8);

	typedef struct packed {
		logic [15:0] page_number;
		logic        restart;
	} lru_in_t;

	typedef struct packed {
		logic        hit;
		logic [2:0]  frame_slot;
		logic        evicted_valid;
		logic [15:0] evicted_page;
		logic [19:0] fault_count;
		logic [19:0] reference_count;
	} lru_out_t;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic exec;
	} lru_cmd_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + CNT_W'(1);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/lru_ctrl.sv =====
`default_nettype none

module lru_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output lru_pkg::lru_cmd_t      cmd
);
	import lru_pkg::*;

	`include "lru_page_replacement_defines.svh"

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic state_d;
	logic out_valid_q;
	logic accept;
	logic out_free;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign cmd.load_in = accept;
	assign cmd.exec    = (state_q == ST_EXEC) && out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (cmd.exec) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	`LRU_ASSERT_NXT(a_accept_exec, accept, state_q == ST_EXEC && in_stall)
	`LRU_ASSERT_IMP(a_rose_after_exec, $rose(out_valid_q), $past(cmd.exec))
	`LRU_ASSERT_NXT(a_wait_on_stall, state_q == ST_EXEC && out_valid_q && out_stall,
		state_q == ST_EXEC)

endmodule

`default_nettype wire

// ===== rtl/lru_dp.sv =====
`default_nettype none

module lru_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lru_pkg::lru_cmd_t cmd,
	input  wire lru_pkg::lru_in_t  in_item,
	input  wire logic              cfg_we,
	input  wire logic [3:0]        cfg_wdata,
	output lru_pkg::lru_out_t      out_item
);
	import lru_pkg::*;

	`include "lru_page_replacement_defines.svh"

	lru_in_t               in_q;
	lru_out_t              out_q;
	logic [CFG_W-1:0]      frame_count_q;
	logic [PAGE_BITS-1:0]  frame_page_q [FRAMES];
	logic [SLOT_W-1:0]     order_q [FRAMES];
	logic [FILL_W-1:0]     filled_q;
	logic [CNT_W-1:0]      faults_q;
	logic [CNT_W-1:0]      refs_q;

	logic [PAGE_BITS-1:0]  page_c;
	logic [FILL_W-1:0]     eff_filled;
	logic [CNT_W-1:0]      eff_faults;
	logic [CNT_W-1:0]      eff_refs;
	logic [FILL_W-1:0]     limit_c;
	logic [FRAMES-1:0]     match_c;
	logic                  hit_c;
	logic [SLOT_W-1:0]     hit_slot;
	logic [SLOT_W-1:0]     pos_c;
	logic                  fill_c;
	logic                  ev_c;
	logic [SLOT_W-1:0]     slot_c;
	logic [PAGE_BITS-1:0]  ev_page_c;
	logic                  promote_c;
	logic [SLOT_W-1:0]     order_d [FRAMES];
	logic [FILL_W-1:0]     filled_d;
	logic [CNT_W-1:0]      faults_d;
	logic [CNT_W-1:0]      refs_d;

	assign page_c     = in_q.page_number[PAGE_BITS-1:0];
	assign eff_filled = in_q.restart ? '0 : filled_q;
	assign eff_faults = in_q.restart ? '0 : faults_q;
	assign eff_refs   = in_q.restart ? '0 : refs_q;

	// zero counts as one frame, anything above the built count is clipped
	always_comb begin
		if (frame_count_q == '0) limit_c = FILL_W'(1);
		else if (32'(frame_count_q) > FRAMES) limit_c = FILL_W'(FRAMES);
		else limit_c = FILL_W'(frame_count_q);
	end

	// only filled frames take part, so no unwritten frame is compared
	always_comb begin
		match_c  = '0;
		hit_slot = '0;
		for (int i = 0; i < FRAMES; i++) begin
			match_c[i] = (FILL_W'(i) < eff_filled) && (frame_page_q[i] == page_c);
			if (match_c[i]) hit_slot = SLOT_W'(i);
		end
		hit_c = |match_c;
	end

	assign fill_c = !hit_c && (eff_filled < limit_c);
	assign ev_c   = !hit_c && !fill_c;

	// recency position of the hit frame
	always_comb begin
		pos_c = '0;
		for (int p = 0; p < FRAMES; p++) begin
			if (hit_c && (FILL_W'(p) < eff_filled) && (order_q[p] == hit_slot))
				pos_c = SLOT_W'(p);
		end
	end

	always_comb begin
		if (hit_c) slot_c = hit_slot;
		else if (fill_c) slot_c = eff_filled[SLOT_W-1:0];
		else slot_c = order_q[0];
	end

	assign ev_page_c = ev_c ? frame_page_q[slot_c] : '0;
	assign promote_c = hit_c || ev_c;

	// move the used frame to the most recent end, or append a new frame
	always_comb begin
		for (int p = 0; p < FRAMES; p++) begin
			order_d[p] = order_q[p];
			if (promote_c) begin
				if ((FILL_W'(p) >= FILL_W'(pos_c)) && (FILL_W'(p + 1) < eff_filled))
					order_d[p] = order_q[(p + 1) % FRAMES];
				if (FILL_W'(p + 1) == eff_filled)
					order_d[p] = slot_c;
			end else if (fill_c && (FILL_W'(p) == eff_filled)) begin
				order_d[p] = slot_c;
			end
		end
	end

	assign filled_d = fill_c ? eff_filled + FILL_W'(1) : eff_filled;
	assign faults_d = hit_c ? eff_faults : sat_inc(eff_faults);
	assign refs_d   = sat_inc(eff_refs);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FRAME_COUNT_RESET;
			filled_q      <= '0;
			faults_q      <= '0;
			refs_q        <= '0;
			for (int p = 0; p < FRAMES; p++) order_q[p] <= '0;
		end else begin
			if (cfg_we) frame_count_q <= cfg_wdata;
			if (cmd.exec) begin
				filled_q <= filled_d;
				faults_q <= faults_d;
				refs_q   <= refs_d;
				for (int p = 0; p < FRAMES; p++) order_q[p] <= order_d[p];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) in_q <= in_item;
		if (cmd.exec && !hit_c) frame_page_q[slot_c] <= page_c;
		if (cmd.exec) begin
			out_q.hit             <= hit_c;
			out_q.frame_slot      <= 3'(slot_c);
			out_q.evicted_valid   <= ev_c;
			out_q.evicted_page    <= 16'(ev_page_c);
			out_q.fault_count     <= faults_d;
			out_q.reference_count <= refs_d;
		end
	end

	assign out_item = out_q;

	`LRU_ASSERT_IMP(a_filled_bound, 1'b1, 32'(filled_q) <= FRAMES)
	`LRU_ASSERT_IMP(a_hit_no_evict, cmd.exec, !(hit_c && ev_c) && !(hit_c && fill_c))
	`LRU_ASSERT_NXT(a_miss_counted, cmd.exec && !hit_c, faults_q != '0)

endmodule

`default_nettype wire

// ===== rtl/lru_page_replacement.sv =====
// channel  | handshake           | payload
// ---------+---------------------+-----------------------------------------
// input    | in_valid, in_stall  | in_item : page_number, restart
// output   | out_valid, out_stall| out_item: hit, slot, eviction, counters
// config   | cfg_we              | cfg_wdata : frame_count (4 bits)
//
// each item is first captured into the input register, then compared
//   against the filled frames with the recency update, and the result registered
// a finished item sits in the output register while the next one is taken in
// output stall holds the update until the output register frees up
// reset clears the recency order, fill count and counters; frame_count to 8
// frame contents are not reset, only filled frames are ever compared
`default_nettype none

module lru_page_replacement (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// reference channel
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire lru_pkg::lru_in_t  in_item,
	// result channel
	output logic                   out_valid,
	input  wire logic              out_stall,
	output lru_pkg::lru_out_t      out_item,
	// frame count register
	input  wire logic              cfg_we,
	input  wire logic [3:0]        cfg_wdata
);
	import lru_pkg::*;

	lru_cmd_t cmd;

	// sequencer: idle, then the update once the output is free
	lru_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// frame store, recency list, counters and output register
	lru_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_item   (in_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire

// ===== bench/lru_page_replacement_tb.sv =====
`timescale 1ns / 1ps

module lru_page_replacement_tb;
	import lru_pkg::*;

	// kinds of row in the directed table
	typedef enum logic [1:0] {
		ROW_REF,    // reference, result worked out by the predictor
		ROW_KNOWN,  // reference with its result written into the table
		ROW_FC      // frame count write, only once the block has gone quiet
	} row_kind_t;

	typedef struct {
		row_kind_t  kind;
		lru_in_t    item;
		lru_out_t   want;
		logic [3:0] fc;
	} stim_row_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	lru_in_t    in_item;
	logic       out_valid;
	logic       out_stall;
	lru_out_t   out_item;
	logic       cfg_we;
	logic [3:0] cfg_wdata;

	// predictor copy of the page table and recency list
	logic [15:0] resident [FRAMES];
	logic [2:0]  lru_order [FRAMES];   // least recent first
	int          filled;
	logic [19:0] fault_tally;
	logic [19:0] ref_tally;
	logic [3:0]  fc_reg;

	// outcomes still owed by the block, oldest first
	lru_out_t    due_outcomes [$];
	stim_row_t   directed [$];

	// sender and receiver idling switches, set per phase
	bit tx_gaps;
	bit rx_gaps;

	int errors;
	int sent;
	int results;
	int hits;
	int evictions;
	int restarts;
	int fc_writes;

	lru_page_replacement DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// move one entry of the recency list to the most recent end
	function automatic void make_newest(int pos);
		logic [2:0] f;
		f = lru_order[pos];
		for (int i = pos; i + 1 < filled; i++)
			lru_order[i] = lru_order[i + 1];
		lru_order[filled - 1] = f;
	endfunction

	// one page reference: hit check over every filled frame, then fill or replace
	function automatic lru_out_t lookup_page(lru_in_t it);
		lru_out_t r;
		int lim;
		int pos;
		logic [2:0] slot;
		r = '0;
		pos = -1;
		if (it.restart) begin
			filled = 0;
			fault_tally = '0;
			ref_tally = '0;
			for (int i = 0; i < FRAMES; i++)
				lru_order[i] = '0;
		end
		// zero behaves as one frame, anything past the built size as all of them
		if (fc_reg == 0)
			lim = 1;
		else if (fc_reg > FRAMES)
			lim = FRAMES;
		else
			lim = fc_reg;
		if (ref_tally != '1)
			ref_tally = ref_tally + 1'b1;
		for (int i = 0; i < filled; i++)
			if (pos < 0 && resident[lru_order[i]] == it.page_number)
				pos = i;
		if (pos >= 0) begin
			r.hit = 1'b1;
			r.frame_slot = lru_order[pos];
			make_newest(pos);
		end else begin
			if (fault_tally != '1)
				fault_tally = fault_tally + 1'b1;
			// surplus frames from a larger count stay resident, so test against filled
			if (filled < lim) begin
				slot = 3'(filled);
				resident[slot] = it.page_number;
				lru_order[filled] = slot;
				filled++;
			end else begin
				slot = lru_order[0];
				r.evicted_valid = 1'b1;
				r.evicted_page = resident[slot];
				resident[slot] = it.page_number;
				make_newest(0);
			end
			r.frame_slot = slot;
		end
		r.fault_count = fault_tally;
		r.reference_count = ref_tally;
		return r;
	endfunction

	task automatic put_ref(logic [15:0] page, logic rst);
		stim_row_t row;
		row.kind = ROW_REF;
		row.item = '{page_number: page, restart: rst};
		row.want = '0;
		row.fc = '0;
		directed.push_back(row);
	endtask

	task automatic put_known(logic [15:0] page, logic rst, lru_out_t want);
		stim_row_t row;
		row.kind = ROW_KNOWN;
		row.item = '{page_number: page, restart: rst};
		row.want = want;
		row.fc = '0;
		directed.push_back(row);
	endtask

	task automatic put_fc(logic [3:0] v);
		stim_row_t row;
		row.kind = ROW_FC;
		row.item = '0;
		row.want = '0;
		row.fc = v;
		directed.push_back(row);
	endtask

	// hold the sender back until every owed outcome is in, then let the pipe settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		wait (due_outcomes.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_frame_count(logic [3:0] v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		fc_reg = v;
		fc_writes++;
	endtask

	// offer one item, keep it steady until taken, then log its outcome
	task automatic send_ref(lru_in_t it, bit known, lru_out_t want);
		lru_out_t predicted;
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_stall);
		predicted = lookup_page(it);
		due_outcomes.push_back(known ? want : predicted);
		sent++;
		restarts += it.restart;
	endtask

	task automatic check_field(string name, logic [19:0] want, logic [19:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// receiver: stall bursts with random gaps between them
	initial begin
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if (rx_gaps && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				out_stall <= 1'b0;
			end
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// result checker, samples the values settled before the edge
	always @(posedge clk) begin
		lru_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_outcomes.size() == 0) begin
				$display("%0t: result with nothing owed, expected none, actual %h",
					$time, out_item);
				errors++;
			end else begin
				want = due_outcomes.pop_front();
				check_field("hit", 20'(want.hit), 20'(out_item.hit));
				check_field("frame_slot", 20'(want.frame_slot), 20'(out_item.frame_slot));
				check_field("evicted_valid", 20'(want.evicted_valid),
					20'(out_item.evicted_valid));
				check_field("evicted_page", 20'(want.evicted_page),
					20'(out_item.evicted_page));
				check_field("fault_count", want.fault_count, out_item.fault_count);
				check_field("reference_count", want.reference_count,
					out_item.reference_count);
				results++;
				hits += (out_item.hit === 1'b1);
				evictions += (out_item.evicted_valid === 1'b1);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("lru_page_replacement_tb failed");
		$finish;
	end

	initial begin
		lru_in_t it;
		logic [15:0] pool [12];
		logic [3:0] plan [11];
		int pool_n;
		int pick;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_item <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		errors = 0;
		sent = 0;
		results = 0;
		hits = 0;
		evictions = 0;
		restarts = 0;
		fc_writes = 0;
		// predictor comes up as the block does after reset
		fc_reg = FRAME_COUNT_RESET;
		filled = 0;
		fault_tally = '0;
		ref_tally = '0;
		for (int i = 0; i < FRAMES; i++) begin
			lru_order[i] = '0;
			resident[i] = '0;
		end

		// directed table, frame count at its reset value of 8 to start with
		put_known(16'h0000, 1'b0, lru_out_t'{1'b0, 3'd0, 1'b0, 16'h0, 20'd1, 20'd1});
		put_known(16'hffff, 1'b0, lru_out_t'{1'b0, 3'd1, 1'b0, 16'h0, 20'd2, 20'd2});
		put_known(16'h0000, 1'b0, lru_out_t'{1'b1, 3'd0, 1'b0, 16'h0, 20'd2, 20'd3});
		// fill the remaining frames, then replace the oldest twice
		for (int p = 1; p <= 6; p++)
			put_ref(16'(p), 1'b0);
		put_ref(16'h8000, 1'b0);
		put_ref(16'hffff, 1'b0);
		// count dropped below the filled frames: the extra frames still hit
		put_fc(4'd3);
		put_ref(16'h0003, 1'b0);
		put_ref(16'h7777, 1'b0);
		// zero acts as a single frame, every miss after the first fill evicts
		put_fc(4'd0);
		put_known(16'h0000, 1'b1, lru_out_t'{1'b0, 3'd0, 1'b0, 16'h0, 20'd1, 20'd1});
		put_known(16'h5555, 1'b0, lru_out_t'{1'b0, 3'd0, 1'b1, 16'h0000, 20'd2, 20'd2});
		put_known(16'haaaa, 1'b0, lru_out_t'{1'b0, 3'd0, 1'b1, 16'h5555, 20'd3, 20'd3});
		put_known(16'haaaa, 1'b0, lru_out_t'{1'b1, 3'd0, 1'b0, 16'h0, 20'd3, 20'd4});
		// fifteen saturates to the built frame count
		put_fc(4'd15);
		put_known(16'h1111, 1'b1, lru_out_t'{1'b0, 3'd0, 1'b0, 16'h0, 20'd1, 20'd1});
		put_ref(16'h2222, 1'b0);
		put_fc(4'd1);
		put_ref(16'h3333, 1'b0);
		put_ref(16'h2222, 1'b0);
		put_fc(4'd8);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_gaps = $urandom_range(0, 1);
		rx_gaps = $urandom_range(0, 1);
		foreach (directed[k]) begin
			if (directed[k].kind == ROW_FC)
				write_frame_count(directed[k].fc);
			else
				send_ref(directed[k].item, directed[k].kind == ROW_KNOWN, directed[k].want);
		end

		// random phases, one frame count each; the last runs with no idling
		plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd2, 4'd5, 4'd8, 4'd6, 4'd7, 4'd4};
		for (int ph = 0; ph < 11; ph++) begin
			write_frame_count(plan[ph]);
			if (ph == 10) begin
				tx_gaps = 1'b0;
				rx_gaps = 1'b0;
			end else begin
				tx_gaps = ($urandom_range(0, 3) != 0);
				rx_gaps = ($urandom_range(0, 3) != 0);
			end
			// a small working set just over the frame count gives a mix of hits and misses
			foreach (pool[k])
				pool[k] = 16'($urandom_range(0, 65535));
			pool_n = ((plan[ph] == 0) ? 1 : (plan[ph] > FRAMES ? FRAMES : plan[ph]))
				+ $urandom_range(1, 4);
			for (int n = 0; n < 64; n++) begin
				// sender holds off until the block has caught up
				if (ph == 5 && n == 32)
					wait_idle();
				it.restart = ($urandom_range(0, 39) == 0);
				pick = $urandom_range(0, 99);
				if (pick < 75)
					it.page_number = pool[$urandom_range(0, pool_n - 1)];
				else if (pick < 80)
					it.page_number = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
				else
					it.page_number = 16'($urandom_range(0, 65535));
				send_ref(it, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		wait (due_outcomes.size() == 0);
		repeat (8) @(posedge clk);

		$display("sent %0d references, checked %0d results: %0d hits, %0d evictions",
			sent, results, hits, evictions);
		$display("%0d restarts across %0d frame count settings", restarts, fc_writes);
		if (errors == 0)
			$display("lru_page_replacement_tb passed");
		else
			$display("lru_page_replacement_tb failed");
		$finish;
	end

endmodule
